// ----- design/sha1_nonce_match_checker_core_defines.svh -----
// Assertion macros used by the checker file
`ifndef SHA1_NONCE_MATCH_CHECKER_CORE_DEFINES_SVH
`define SHA1_NONCE_MATCH_CHECKER_CORE_DEFINES_SVH
// a -> b in the next cycle, off during reset
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m failed");
// a implies b in the same cycle
`define ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m failed");
`endif

// ----- design/snm_pkg.sv -----
// Package: SHA-1 constants, types and round helpers
`timescale 1ns / 1ps
package snm_pkg;
  localparam int MaxNonceBytes = 19;
  localparam int PrefixLen = 40;
  localparam int Rounds = 80;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = 2;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [2:0] RegTarget01 = 3'd5;
  localparam logic [2:0] RegTarget23 = 3'd6;
  localparam logic [2:0] RegTarget4 = 3'd7;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] sched_t;
  typedef struct packed {
    word_t a, b, c, d, e;
  } hstate_t;

  function automatic word_t rotl(word_t x, int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  function automatic hstate_t sha_round(hstate_t s, word_t w, int unsigned i);
    word_t f, k, t;
    if (i < 20) begin
      f = (s.b & s.c) | (~s.b & s.d); k = K0;
    end else if (i < 40) begin
      f = s.b ^ s.c ^ s.d; k = K1;
    end else if (i < 60) begin
      f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d); k = K2;
    end else begin
      f = s.b ^ s.c ^ s.d; k = K3;
    end
    t = rotl(s.a, 5) + f + s.e + w + k;
    sha_round.e = s.d;
    sha_round.d = s.c;
    sha_round.c = rotl(s.b, 30);
    sha_round.b = s.a;
    sha_round.a = t;
  endfunction
endpackage

// ----- design/snm_stream_if.sv -----
// Valid/ready stream interface
`timescale 1ns / 1ps
interface snm_stream_if #(parameter int Width = 1) (input logic clk);
  logic valid;
  logic ready;
  logic [Width-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- design/snm_front.sv -----
// Front end: length saturation and message block assembly
`timescale 1ns / 1ps
module snm_front import snm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic [63:0] nonce_bytes_0_7,
  input logic [63:0] nonce_bytes_8_15,
  input logic [23:0] nonce_bytes_16_18,
  input logic [4:0] nonce_length,
  input logic in_valid,
  output logic in_ready,
  output logic [151:0] blk_nonce,
  output logic [4:0] blk_len,
  output logic blk_valid,
  input logic blk_ready
);
  logic [151:0] raw;
  logic [151:0] masked;
  logic [4:0] len_sat;

  assign raw = {nonce_bytes_0_7, nonce_bytes_8_15, nonce_bytes_16_18};
  assign len_sat = (nonce_length > 5'(MaxNonceBytes)) ? 5'(MaxNonceBytes) : nonce_length;

  // keep bytes below len, put pad byte at len, zero the rest
  always_comb begin
    for (int j = 0; j < MaxNonceBytes; j++) begin
      if (5'(j) < len_sat) masked[151-8*j -: 8] = raw[151-8*j -: 8];
      else if (5'(j) == len_sat) masked[151-8*j -: 8] = PadByte;
      else masked[151-8*j -: 8] = 8'h00;
    end
  end

  assign in_ready = !blk_valid || blk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (in_ready) begin
      blk_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      blk_nonce <= masked;
      blk_len <= len_sat;
    end
  end
endmodule

// ----- design/snm_queue.sv -----
// Short FIFO between front and back ends
`timescale 1ns / 1ps
module snm_queue import snm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic [156:0] wr_data,
  input logic wr_valid,
  output logic wr_ready,
  output logic [156:0] rd_data,
  output logic rd_valid,
  input logic rd_ready
);
  logic [156:0] mem [QueueDepth];
  logic [QueuePtrW-1:0] wp, rp;
  logic [QueuePtrW:0] count;
  logic push, pop;

  assign wr_ready = count != (QueuePtrW+1)'(QueueDepth);
  assign rd_valid = count != '0;
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
    if (push) mem[wp] <= wr_data;
  end
endmodule

// ----- design/snm_back.sv -----
// Back end: 80-stage SHA-1 round pipeline and target compare
`timescale 1ns / 1ps
module snm_back import snm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic [319:0] prefix,
  input logic [159:0] target,
  input logic [156:0] job,
  input logic job_valid,
  output logic job_ready,
  output logic match,
  output logic match_valid,
  input logic match_ready
);
  hstate_t st [Rounds+1];
  sched_t sc [Rounds+1];
  logic vld [Rounds+1];
  logic adv;
  logic [511:0] blk;
  logic [7:0] tail_byte;
  hstate_t fin;

  // pipeline moves as one; output stage is the last one
  assign adv = !vld[Rounds] || match_ready;
  assign job_ready = adv;
  // a full-length nonce pushes the pad byte into the last byte before the length word
  assign tail_byte = (job[4:0] == 5'(MaxNonceBytes)) ? PadByte : 8'h00;
  assign blk = {prefix, job[156:5], tail_byte, 32'((PrefixLen + 32'(job[4:0])) * 8)};

  assign st[0] = '{a: H0, b: H1, c: H2, d: H3, e: H4};
  assign vld[0] = job_valid;
  always_comb begin
    for (int i = 0; i < 16; i++) sc[0][i] = blk[511-32*i -: 32];
  end

  for (genvar r = 0; r < Rounds; r++) begin : g_rnd
    always_ff @(posedge clk) begin
      if (rst) vld[r+1] <= 1'b0;
      else if (adv) vld[r+1] <= vld[r];
      if (adv) begin
        st[r+1] <= sha_round(st[r], sc[r][0], r);
        sc[r+1] <= {rotl(sc[r][13] ^ sc[r][8] ^ sc[r][2] ^ sc[r][0], 1), sc[r][15:1]};
      end
    end
  end

  assign fin = st[Rounds];
  assign match_valid = vld[Rounds];
  assign match = (fin.a + H0 == target[159:128]) && (fin.b + H1 == target[127:96]) &&
                 (fin.c + H2 == target[95:64]) && (fin.d + H3 == target[63:32]) &&
                 (fin.e + H4 == target[31:0]);
endmodule

// ----- design/sha1_nonce_match_checker_core.sv -----
// Top level: SHA-1 nonce match checker
// Path: front register loads at the input transfer, then the queue write,
//   then 80 round stages; the result is held in the last stage.
// Throughput: one nonce per cycle unless the output stalls; 80 rounds fully unrolled.
// Reset: rst (synchronous, high) clears config registers to zero and all valids.
`timescale 1ns / 1ps
module sha1_nonce_match_checker_core import snm_pkg::*; (
  input logic clk,
  input logic rst,
  snm_stream_if.sink in_ch,
  snm_stream_if.source out_ch,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [63:0] cfg_data
);
  logic [63:0] prefix_r [5];
  logic [159:0] target;
  logic [151:0] f_nonce;
  logic [4:0] f_len;
  logic f_valid, f_ready;
  logic [156:0] q_data;
  logic q_valid, q_ready;

  // config: prefix regs 0..4, then target parts 5..7; index is 3 bits so all are legal
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) prefix_r[i] <= '0;
      target <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegTarget01) target[159:96] <= cfg_data;
      else if (cfg_index == RegTarget23) target[95:32] <= cfg_data;
      else if (cfg_index == RegTarget4) target[31:0] <= cfg_data[31:0];
      else prefix_r[cfg_index] <= cfg_data;
    end
  end

  // front: mask bytes, place pad, saturate length
  snm_front u_front (
    .clk, .rst,
    .nonce_bytes_0_7(in_ch.data[156:93]),
    .nonce_bytes_8_15(in_ch.data[92:29]),
    .nonce_bytes_16_18(in_ch.data[28:5]),
    .nonce_length(in_ch.data[4:0]),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .blk_nonce(f_nonce), .blk_len(f_len),
    .blk_valid(f_valid), .blk_ready(f_ready)
  );

  // decoupling queue
  snm_queue u_queue (
    .clk, .rst,
    .wr_data({f_nonce, f_len}), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_data), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  // back: rounds and compare; last stage doubles as the output register
  snm_back u_back (
    .clk, .rst,
    .prefix({prefix_r[0], prefix_r[1], prefix_r[2], prefix_r[3], prefix_r[4]}),
    .target,
    .job(q_data), .job_valid(q_valid), .job_ready(q_ready),
    .match(out_ch.data[0]), .match_valid(out_ch.valid), .match_ready(out_ch.ready)
  );
endmodule

// ----- design/snm_checker.sv -----
// Port-level checker and bind for the top level
`timescale 1ns / 1ps
`include "sha1_nonce_match_checker_core_defines.svh"
module snm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_data
);
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_data))
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)
  `ASSERT_NOW(a_in_ready_known, clk, rst, in_valid, !$isunknown(in_ready))
  `ASSERT_NOW(a_out_data_known, clk, rst, out_valid, !$isunknown(out_data))
endmodule

bind sha1_nonce_match_checker_core snm_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data[0])
);

// ----- tb/sha1_nonce_match_checker_core_tb.sv -----
// Testbench for the SHA-1 nonce match checker: directed and random nonces vs. a local digest model
`timescale 1ns / 1ps
module sha1_nonce_match_checker_core_tb;
  import snm_pkg::*;

  // Prefix registers occupy indexes 0..4; the target ones come from the package.
  localparam logic [2:0] RegPrefixBase = 3'd0;
  localparam int InW = 64 + 64 + 24 + 5;
  localparam int DrainCycles = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  snm_stream_if #(.Width(InW)) in_ch (clk);
  snm_stream_if #(.Width(1)) out_ch (clk);

  sha1_nonce_match_checker_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Local copy of the configuration, updated as each register write goes out.
  logic [63:0] prefix_words [5];
  logic [159:0] target_digest;

  // One match flag per accepted nonce, oldest first.
  bit match_queue [$];
  int errors = 0;

  // Idle controls, changed per phase by the test tasks.
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_off_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    foreach (prefix_words[i]) prefix_words[i] = '0;
    target_digest = '0;
  end

  function automatic logic [31:0] rol(logic [31:0] x, int r);
    rol = (x << r) | (x >> (32 - r));
  endfunction

  // Full single-block SHA-1 of prefix + masked nonce + padding + bit length.
  function automatic logic [159:0] nonce_digest(logic [63:0] n0, logic [63:0] n1,
                                                logic [23:0] n2, logic [4:0] len_in);
    logic [7:0] blk [64];
    logic [31:0] w [80];
    logic [151:0] nb;
    logic [31:0] a, b, c, d, e, f, k, t;
    int len, i;
    len = (len_in > MaxNonceBytes) ? MaxNonceBytes : int'(len_in);
    nb = {n0, n1, n2};
    for (i = 0; i < 64; i++) blk[i] = 8'h00;
    for (i = 0; i < PrefixLen; i++) blk[i] = prefix_words[i / 8][63 - 8 * (i % 8) -: 8];
    for (i = 0; i < len; i++) blk[PrefixLen + i] = nb[151 - 8 * i -: 8];
    blk[PrefixLen + len] = PadByte;
    for (i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    w[15] = 32'((PrefixLen + len) * 8);
    for (i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = H0; b = H1; c = H2; d = H3; e = H4;
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + w[i] + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    nonce_digest = {a + H0, b + H1, c + H2, d + H3, e + H4};
  endfunction

  // Predict on each input transfer, check on each output transfer.
  always @(posedge clk) begin
    bit exp_match;
    if (!rst && in_ch.valid && in_ch.ready)
      match_queue.push_back(nonce_digest(in_ch.data[156:93], in_ch.data[92:29],
                                         in_ch.data[28:5], in_ch.data[4:0]) == target_digest);
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (match_queue.size() == 0) begin
        $error("hash_matches: result with no nonce outstanding (actual %0b)", out_ch.data[0]);
        errors++;
      end else begin
        exp_match = match_queue.pop_front();
        if (out_ch.data[0] !== exp_match) begin
          $error("hash_matches: expected %0b actual %0b", exp_match, out_ch.data[0]);
          errors++;
        end
      end
    end
  end

  // Receiver: a long hold-off wins over the random stall.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_off_cycles--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = value;
    if (idx < RegTarget01) prefix_words[idx - RegPrefixBase] = value;
    else if (idx == RegTarget01) target_digest[159:96] = value;
    else if (idx == RegTarget23) target_digest[95:32] = value;
    else target_digest[31:0] = value[31:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_prefix(logic [63:0] p0, p1, p2, p3, p4);
    cfg_write(RegPrefixBase + 3'd0, p0);
    cfg_write(RegPrefixBase + 3'd1, p1);
    cfg_write(RegPrefixBase + 3'd2, p2);
    cfg_write(RegPrefixBase + 3'd3, p3);
    cfg_write(RegPrefixBase + 3'd4, p4);
  endtask

  // Load the target with the digest of a given nonce so that nonce matches.
  task automatic aim_at(logic [63:0] n0, logic [63:0] n1, logic [23:0] n2, logic [4:0] len);
    logic [159:0] dg;
    dg = nonce_digest(n0, n1, n2, len);
    cfg_write(RegTarget01, dg[159:96]);
    cfg_write(RegTarget23, dg[95:32]);
    cfg_write(RegTarget4, {32'h0, dg[31:0]});
  endtask

  // One nonce transfer; random idle cycles ahead of it.
  task automatic send_nonce(logic [63:0] n0, logic [63:0] n1, logic [23:0] n2, logic [4:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = {n0, n1, n2, len};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Block is idle once every result is back, plus pipeline settling time.
  task automatic wait_drain();
    while (match_queue.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [151:0] rand_bytes();
    rand_bytes = {$urandom, $urandom, $urandom, $urandom, 24'($urandom)};
  endfunction

  // Zero config: digests never hit an all-zero target.
  task automatic test_reset_config();
    send_nonce('0, '0, '0, 5'd0);
    send_nonce('1, '1, '1, 5'd19);
    send_nonce('1, '1, '1, 5'd31);
    wait_drain();
  endtask

  // Hits and misses around the target: masking past the length, saturation, length zero.
  task automatic test_directed();
    logic [151:0] nb;
    set_prefix(64'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, '1, '0);
    nb = rand_bytes();
    aim_at(nb[151:88], nb[87:24], nb[23:0], 5'd7);
    send_nonce(nb[151:88], nb[87:24], nb[23:0], 5'd7);
    // junk beyond byte 7 must be ignored
    send_nonce({nb[151:96], 8'hFF}, '1, '1, 5'd7);
    send_nonce(nb[151:88], nb[87:24], nb[23:0], 5'd8);
    send_nonce(nb[151:88] ^ 64'h1, nb[87:24], nb[23:0], 5'd7);
    wait_drain();
    // oversized length saturates to the maximum
    aim_at(nb[151:88], nb[87:24], nb[23:0], 5'd19);
    send_nonce(nb[151:88], nb[87:24], nb[23:0], 5'd19);
    send_nonce(nb[151:88], nb[87:24], nb[23:0], 5'd20);
    send_nonce(nb[151:88], nb[87:24], nb[23:0], 5'd31);
    send_nonce(nb[151:88], nb[87:24], nb[23:0] ^ 24'h1, 5'd31);
    wait_drain();
    // empty nonce: every data byte is don't-care
    aim_at('0, '0, '0, 5'd0);
    send_nonce('0, '0, '0, 5'd0);
    send_nonce('1, '1, '1, 5'd0);
    send_nonce('0, '0, '0, 5'd1);
    wait_drain();
    // extreme prefixes and target
    set_prefix('1, '1, '1, '1, '1);
    aim_at('1, '1, '1, 5'd16);
    send_nonce('1, '1, '0, 5'd16);
    send_nonce('1, '1, '1, 5'd17);
    wait_drain();
    cfg_write(RegTarget01, '1);
    cfg_write(RegTarget23, '1);
    cfg_write(RegTarget4, '1);
    send_nonce('1, '1, '1, 5'd16);
    wait_drain();
  endtask

  // Random phase: fresh config, then nonces that often share the aimed-at
  // bytes (with random junk past the length) and otherwise random.
  task automatic run_random_phase(int n_items, int idle_pct, int stall_pct);
    logic [151:0] base, junk, mask, nb;
    logic [4:0] base_len, len;
    wait_drain();
    set_prefix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
    base = rand_bytes();
    base_len = 5'($urandom_range(MaxNonceBytes));
    aim_at(base[151:88], base[87:24], base[23:0], base_len);
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (n_items) begin
      junk = rand_bytes();
      if ($urandom_range(99) < 45) begin
        len = (base_len == MaxNonceBytes) ? 5'($urandom_range(31, MaxNonceBytes)) : base_len;
        mask = ~({152{1'b1}} >> (8 * base_len));
        nb = (base & mask) | (junk & ~mask);
        // occasionally flip one valid byte bit for a near miss
        if (base_len != 0 && $urandom_range(9) == 0) nb[151 - $urandom_range(8 * base_len - 1)] ^= 1'b1;
      end else begin
        nb = junk;
        len = 5'($urandom_range(31));
      end
      send_nonce(nb[151:88], nb[87:24], nb[23:0], len);
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  // Output held off long enough to fill the pipeline and push back on the input.
  task automatic test_backpressure();
    logic [151:0] nb;
    wait_drain();
    hold_off_cycles = 400;
    repeat (150) begin
      nb = rand_bytes();
      send_nonce(nb[151:88], nb[87:24], nb[23:0], 5'($urandom_range(31)));
    end
    // sender pause until everything is back, then resume
    while (match_queue.size() != 0) @(negedge clk);
    repeat (5) begin
      nb = rand_bytes();
      send_nonce(nb[151:88], nb[87:24], nb[23:0], 5'($urandom_range(31)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_config();
    test_directed();
    run_random_phase(350, 0, 0);
    run_random_phase(350, 83, 0);
    run_random_phase(350, 0, 83);
    run_random_phase(350, 19, 19);
    test_backpressure();
    run_random_phase(150, 19, 19);
    wait_drain();
    if (errors == 0) begin
      $display("sha1_nonce_match_checker_core_tb: clean");
    end else begin
      $display("sha1_nonce_match_checker_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("sha1_nonce_match_checker_core_tb: errors");
    $finish;
  end
endmodule
